@@ rtl/core/csbm_pkg.sv @@
package csbm_pkg;

	// Reset values of the control registers and the timer step
	localparam logic [4:0]  REG0_RESET      = 5'h0C;
	localparam logic [4:0]  REG3_RESET      = 5'h10;
	localparam logic [15:0] FRAME_INC_RESET = 16'd29781;

	// Register select code of the control register
	localparam logic [1:0] SEL_CTRL = 2'd0;

	// Shifter length in bits
	localparam logic [2:0] SHIFT_LEN = 3'd5;

	// Startup writes that skip the bank update
	localparam logic [1:0] STARTUP_DONE = 2'd2;

	// Item kinds
	localparam logic KIND_WRITE    = 1'b0;
	localparam logic KIND_SCANLINE = 1'b1;

	// Configuration register indexes
	localparam logic CFG_FRAME_INC = 1'b0;

	// Nametable mirroring codes
	localparam logic [3:0] MIR_SINGLE0 = 4'h0;
	localparam logic [3:0] MIR_SINGLE1 = 4'hF;
	localparam logic [3:0] MIR_VERT    = 4'hA;
	localparam logic [3:0] MIR_HORZ    = 4'hC;

	// Timer width
	localparam int TIMER_W = 29;

	// Control register contents after a write item
	typedef struct packed {
		logic [4:0] r0;
		logic [4:0] r1;
		logic [4:0] r3;
		logic       bank_upd;
	} ctrl_upd_t;

	// Commands to the frame timer for one item
	typedef struct packed {
		logic clear;
		logic enable;
		logic tick;
	} timer_cmd_t;

endpackage

@@ rtl/core/cartridge_serial_bank_mapper.sv @@
// Serial bank mapper with a frame timer. Each item (CPU write or scanline
// event) is taken into an input register and moves on into the result
// register once that register is free, so one item is accepted every cycle
// unless the result register is stalled. The result register holds the bank
// slots, mirroring and IRQ flag; a stalled result blocks new items only when
// the input register is also occupied. frame_increment is written through the
// APB port at byte address 0.
module cartridge_serial_bank_mapper import csbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [8:0]  scanline,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  slot0_bank,
	output logic [4:0]  slot1_bank,
	output logic [4:0]  slot2_bank,
	output logic [4:0]  slot3_bank,
	output logic [3:0]  nametable_map,
	output logic        irq_request,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic        s1_valid_q;
	logic        kind_s1;
	logic [1:0]  sel_s1;
	logic [7:0]  data_s1;
	logic        line0_s1;
	logic        out_valid_q;
	logic [4:0]  slot_q [4];
	logic [3:0]  mirror_q;
	logic        irq_q;
	logic [15:0] frame_inc_q;

	logic        load;
	logic        adv;
	logic        wr_step;
	ctrl_upd_t   upd;
	timer_cmd_t  tcmd;
	logic        irq_hit;
	logic [4:0]  slot_n [4];
	logic [3:0]  mirror_n;

	// Handshake: the input register moves on when the result register is free
	assign adv      = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && out_valid_q && out_stall;
	assign load     = in_valid && !in_stall;
	assign wr_step  = adv && (kind_s1 == KIND_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (load) begin
			kind_s1  <= kind;
			sel_s1   <= address[14:13];
			data_s1  <= write_data;
			line0_s1 <= (scanline == 9'd0);
		end
	end

	csbm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (wr_step),
		.sel        (sel_s1),
		.write_data (data_s1),
		.upd        (upd)
	);

	assign tcmd.clear  = upd.bank_upd && upd.r1[4];
	assign tcmd.enable = upd.bank_upd && !upd.r1[4];
	assign tcmd.tick   = adv && (kind_s1 == KIND_SCANLINE) && line0_s1;

	csbm_timer u_timer (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (tcmd),
		.frame_increment (frame_inc_q),
		.irq_hit         (irq_hit)
	);

	// Map the control registers onto the four program slots
	always_comb begin
		if (upd.r1[3]) begin
			if (upd.r0[3]) begin
				if (upd.r0[2]) begin
					slot_n[0] = {1'b1, upd.r3[2:0], 1'b0};
					slot_n[1] = {1'b1, upd.r3[2:0], 1'b1};
					slot_n[2] = 5'd30;
					slot_n[3] = 5'd31;
				end else begin
					slot_n[0] = 5'd16;
					slot_n[1] = 5'd17;
					slot_n[2] = {1'b1, upd.r3[2:0], 1'b0};
					slot_n[3] = {1'b1, upd.r3[2:0], 1'b1};
				end
			end else begin
				slot_n[0] = {1'b1, upd.r3[2:1], 2'd0};
				slot_n[1] = {1'b1, upd.r3[2:1], 2'd1};
				slot_n[2] = {1'b1, upd.r3[2:1], 2'd2};
				slot_n[3] = {1'b1, upd.r3[2:1], 2'd3};
			end
		end else begin
			slot_n[0] = {1'b0, upd.r1[2:1], 2'd0};
			slot_n[1] = {1'b0, upd.r1[2:1], 2'd1};
			slot_n[2] = {1'b0, upd.r1[2:1], 2'd2};
			slot_n[3] = {1'b0, upd.r1[2:1], 2'd3};
		end
	end

	// Decode nametable mirroring from the control register
	always_comb begin
		case (upd.r0[1:0])
			2'b00:   mirror_n = MIR_SINGLE0;
			2'b01:   mirror_n = MIR_SINGLE1;
			2'b10:   mirror_n = MIR_VERT;
			2'b11:   mirror_n = MIR_HORZ;
			default: mirror_n = MIR_SINGLE0;
		endcase
	end

	// Result register doubles as the bank and mirroring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q[0] <= 5'd0;
			slot_q[1] <= 5'd1;
			slot_q[2] <= 5'd2;
			slot_q[3] <= 5'd3;
			mirror_q  <= '0;
			irq_q     <= 1'b0;
		end else if (adv) begin
			irq_q <= tcmd.tick && irq_hit;
			if (wr_step) begin
				mirror_q <= mirror_n;
			end
			if (upd.bank_upd) begin
				slot_q <= slot_n;
			end
		end
	end

	// Configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_inc_q <= FRAME_INC_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == CFG_FRAME_INC)) begin
			frame_inc_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == CFG_FRAME_INC) ? {16'd0, frame_inc_q} : '0;
	assign pready = 1'b1;

	assign out_valid     = out_valid_q;
	assign slot0_bank    = slot_q[0];
	assign slot1_bank    = slot_q[1];
	assign slot2_bank    = slot_q[2];
	assign slot3_bank    = slot_q[3];
	assign nametable_map = mirror_q;
	assign irq_request   = irq_q;

	// A write item never raises an interrupt
	a_write_no_irq: assert property (@(posedge clk) disable iff (!arst_n)
		wr_step |=> !irq_request) else $error("irq raised by a write item");

	// Banks change only after a write item past startup
	a_bank_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd.bank_upd |=> $stable(slot0_bank) && $stable(slot3_bank))
		else $error("bank slots moved without an update");

endmodule

@@ rtl/core/csbm_ctrl.sv @@
module csbm_ctrl import csbm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [1:0] sel,
	input  logic [7:0] write_data,
	output ctrl_upd_t  upd
);

	logic [4:0] shift_value_q;
	logic [2:0] shift_count_q;
	logic [4:0] regs_q [4];
	logic [1:0] startup_q;

	logic [4:0] shift_value_n;
	logic [2:0] shift_count_n;
	logic [4:0] regs_n [4];

	// Shift in the serial bit, or clear the shifter; a full shifter is copied into the selected register
	always_comb begin
		logic [2:0] cnt_inc;
		logic [4:0] val_or;
		cnt_inc = shift_count_q + 3'd1;
		val_or  = shift_value_q | (5'({4'd0, write_data[0]}) << shift_count_q);
		regs_n        = regs_q;
		shift_value_n = val_or;
		shift_count_n = cnt_inc;
		if (write_data[7]) begin
			shift_value_n = '0;
			shift_count_n = '0;
			if (sel == SEL_CTRL) begin
				regs_n[0] = regs_q[0] | REG0_RESET;
			end
		end else if (cnt_inc >= SHIFT_LEN) begin
			regs_n[sel]   = val_or;
			shift_value_n = '0;
			shift_count_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_value_q <= '0;
			shift_count_q <= '0;
			regs_q[0]     <= REG0_RESET;
			regs_q[1]     <= '0;
			regs_q[2]     <= '0;
			regs_q[3]     <= REG3_RESET;
			startup_q     <= '0;
		end else if (step) begin
			shift_value_q <= shift_value_n;
			shift_count_q <= shift_count_n;
			regs_q        <= regs_n;
			if (startup_q != STARTUP_DONE) begin
				startup_q <= startup_q + 2'd1;
			end
		end
	end

	assign upd.r0       = regs_n[0];
	assign upd.r1       = regs_n[1];
	assign upd.r3       = regs_n[3];
	assign upd.bank_upd = step && (startup_q == STARTUP_DONE);

	// The shifter reloads before it ever reaches its full length
	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		shift_count_q < SHIFT_LEN) else $error("shift count past shifter length");

	// Startup count saturates and never moves backward
	a_startup: assert property (@(posedge clk) disable iff (!arst_n)
		$past(startup_q) == STARTUP_DONE |-> startup_q == STARTUP_DONE)
		else $error("startup count left its final value");

endmodule

@@ rtl/core/csbm_timer.sv @@
module csbm_timer import csbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  timer_cmd_t  cmd,
	input  logic [15:0] frame_increment,
	output logic        irq_hit
);

	logic [TIMER_W-1:0] count_q;
	logic               enabled_q;
	logic [TIMER_W-1:0] count_n;

	// Advance the timer by frame_increment on a tick when enabled, or clear it
	always_comb begin
		count_n = count_q;
		if (cmd.clear) begin
			count_n = '0;
		end else if (cmd.tick && enabled_q) begin
			count_n = count_q + TIMER_W'(frame_increment);
		end
	end

	assign irq_hit = &count_n[TIMER_W-1 -: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			enabled_q <= 1'b0;
		end else begin
			count_q <= count_n;
			if (cmd.clear) begin
				enabled_q <= 1'b0;
			end else if (cmd.enable) begin
				enabled_q <= 1'b1;
			end
		end
	end

	// A disabled timer holds its count
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!enabled_q && !cmd.clear |=> $stable(count_q))
		else $error("disabled timer moved");

endmodule
